// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hidrdw_pkg.sv -----
package hidrdw_pkg;

  localparam logic [1:0] KIND_MAIN   = 2'd0;
  localparam logic [1:0] KIND_GLOBAL = 2'd1;

  localparam logic [3:0] TAG_PAGE   = 4'h0;
  localparam logic [3:0] TAG_RSIZE  = 4'h7;
  localparam logic [3:0] TAG_INPUTS = 4'h8;
  localparam logic [3:0] TAG_RCOUNT = 4'h9;

  localparam logic [31:0] PAGE_KBD    = 32'h0000_0007;
  localparam logic [31:0] PAGE_BUTTON = 32'h0000_0009;

  localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] first_page;
    logic        kbd_found;
    logic        button_found;
    logic [15:0] bit_sum;
    logic [15:0] input_count;
  } out_beat_t;

  // Number of data bytes that follow a short-item prefix.
  function automatic logic [2:0] data_len(input logic [7:0] prefix);
    logic [2:0] len;
    if (prefix[1:0] == SIZE_CODE_FOUR) begin
      len = 3'd4;
    end else begin
      len = {1'b0, prefix[1:0]};
    end
    return len;
  endfunction

endpackage

// ----- src/hid_report_descriptor_walker_unit.sv -----
// Walks a HID report descriptor at one byte per clock cycle while in_stall
// is low: every beat is registered on entry, decoded against the walker
// state by combinational logic (prefix decode, little-endian gathering and
// a 16x16 multiply-add into the bit total), and the totals are loaded into
// the output register when the beat carrying the final-byte flag leaves the
// entry register. The input side stalls only when a final-byte beat meets a
// result that is still waiting to be taken; all other beats keep flowing
// while the output is stalled. After the final byte the walker state is
// cleared and the next beat starts a fresh descriptor.
`include "assert_macros.svh"

module hid_report_descriptor_walker_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hidrdw_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hidrdw_pkg::out_beat_t out_data
);
  import hidrdw_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_beat_t  s1_beat_r, s1_beat_nxt;
  logic      s1_adv;
  logic      in_take;
  logic      last_held;
  logic      last_adv;
  logic      out_take;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  out_beat_t totals;

  assign last_held = s1_beat_r.last_byte && out_valid_r && out_stall;
  assign s1_adv    = s1_valid_r && !last_held;
  assign last_adv  = s1_adv && s1_beat_r.last_byte;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_take   = in_valid && !in_stall;

  hidrdw_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .beat   (s1_beat_r),
    .totals (totals)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_beat_nxt  = s1_beat_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_beat_nxt  = in_data;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_adv && s1_beat_r.last_byte) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = totals;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_beat_r  <= s1_beat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, last_held, "stall without a waiting result")
  `ASSERT_NEXT(a_last_result, clk, rst_n, last_adv, out_valid_r, "final byte gave no result")
  `ASSERT_NEXT(a_no_repeat, clk, rst_n, out_take && !last_adv, !out_valid_r, "result repeated")

endmodule

// ----- src/hidrdw_core.sv -----
module hidrdw_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  hidrdw_pkg::in_beat_t  beat,
  output hidrdw_pkg::out_beat_t totals
);
  import hidrdw_pkg::*;

  logic [2:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  prefix_r, prefix_nxt;
  logic [31:0] value_r, value_nxt;
  logic [15:0] size_r, size_nxt;
  logic [15:0] count_r, count_nxt;
  logic        page_seen_r, page_seen_nxt;
  logic [15:0] page_r, page_nxt;
  logic        kbd_r, kbd_nxt;
  logic        mouse_r, mouse_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] inputs_r, inputs_nxt;

  logic [2:0]  left_c;
  logic [7:0]  prefix_c;
  logic [31:0] value_c;
  logic        complete_c;
  logic [2:0]  pos_diff;
  logic [1:0]  pos_c;
  logic [1:0]  kind_c;
  logic [3:0]  tag_c;
  logic [31:0] prod_c;
  logic [15:0] size_c, count_c, page_c, bits_c, inputs_c;
  logic        page_seen_c, kbd_c, mouse_c;

  always_comb begin
    pos_diff = data_len(prefix_r) - bytes_left_r;
    pos_c    = pos_diff[1:0];
    if (bytes_left_r == 3'd0) begin
      prefix_c   = beat.desc_byte;
      value_c    = 32'd0;
      left_c     = data_len(beat.desc_byte);
      complete_c = (left_c == 3'd0);
    end else begin
      prefix_c   = prefix_r;
      value_c    = value_r | ({24'd0, beat.desc_byte} << {pos_c, 3'b000});
      left_c     = bytes_left_r - 3'd1;
      complete_c = (left_c == 3'd0);
    end
  end

  assign kind_c = prefix_c[3:2];
  assign tag_c  = prefix_c[7:4];
  assign prod_c = {16'd0, size_r} * {16'd0, count_r};

  always_comb begin
    size_c      = size_r;
    count_c     = count_r;
    page_seen_c = page_seen_r;
    page_c      = page_r;
    kbd_c       = kbd_r;
    mouse_c     = mouse_r;
    bits_c      = bits_r;
    inputs_c    = inputs_r;
    if (complete_c) begin
      if (kind_c == KIND_GLOBAL && tag_c == TAG_PAGE) begin
        if (!page_seen_r) begin
          page_c      = value_c[15:0];
          page_seen_c = 1'b1;
        end
        if (value_c == PAGE_KBD) begin
          kbd_c = 1'b1;
        end
        if (value_c == PAGE_BUTTON) begin
          mouse_c = 1'b1;
        end
      end else if (kind_c == KIND_GLOBAL && tag_c == TAG_RSIZE) begin
        size_c = value_c[15:0];
      end else if (kind_c == KIND_GLOBAL && tag_c == TAG_RCOUNT) begin
        count_c = value_c[15:0];
      end else if (kind_c == KIND_MAIN && tag_c == TAG_INPUTS) begin
        bits_c   = bits_r + prod_c[15:0];
        inputs_c = inputs_r + 16'd1;
      end
    end
  end

  assign totals.first_page   = page_c;
  assign totals.kbd_found    = kbd_c;
  assign totals.button_found = mouse_c;
  assign totals.bit_sum      = bits_c;
  assign totals.input_count  = inputs_c;

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    prefix_nxt     = prefix_r;
    value_nxt      = value_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    page_seen_nxt  = page_seen_r;
    page_nxt       = page_r;
    kbd_nxt        = kbd_r;
    mouse_nxt      = mouse_r;
    bits_nxt       = bits_r;
    inputs_nxt     = inputs_r;
    if (step) begin
      if (beat.last_byte) begin
        bytes_left_nxt = 3'd0;
        prefix_nxt     = 8'd0;
        value_nxt      = 32'd0;
        size_nxt       = 16'd0;
        count_nxt      = 16'd0;
        page_seen_nxt  = 1'b0;
        page_nxt       = 16'd0;
        kbd_nxt        = 1'b0;
        mouse_nxt      = 1'b0;
        bits_nxt       = 16'd0;
        inputs_nxt     = 16'd0;
      end else begin
        bytes_left_nxt = left_c;
        prefix_nxt     = prefix_c;
        value_nxt      = value_c;
        size_nxt       = size_c;
        count_nxt      = count_c;
        page_seen_nxt  = page_seen_c;
        page_nxt       = page_c;
        kbd_nxt        = kbd_c;
        mouse_nxt      = mouse_c;
        bits_nxt       = bits_c;
        inputs_nxt     = inputs_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 3'd0;
      prefix_r     <= 8'd0;
      value_r      <= 32'd0;
      size_r       <= 16'd0;
      count_r      <= 16'd0;
      page_seen_r  <= 1'b0;
      page_r       <= 16'd0;
      kbd_r        <= 1'b0;
      mouse_r      <= 1'b0;
      bits_r       <= 16'd0;
      inputs_r     <= 16'd0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      prefix_r     <= prefix_nxt;
      value_r      <= value_nxt;
      size_r       <= size_nxt;
      count_r      <= count_nxt;
      page_seen_r  <= page_seen_nxt;
      page_r       <= page_nxt;
      kbd_r        <= kbd_nxt;
      mouse_r      <= mouse_nxt;
      bits_r       <= bits_nxt;
      inputs_r     <= inputs_nxt;
    end
  end

endmodule
